[sv/cv3_pkg.sv]
package cv3_pkg;

	localparam int COL_W = 11;
	localparam int ROW_W = 12;
	localparam int ACC_W = 28;
	localparam int REC_W = 24;
	localparam int COEF_W = 48;
	localparam int CFG_AW = 6;
	localparam int CFG_DW = 64;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_COEF_TOP = 3'd2;
	localparam logic [2:0] REG_COEF_MID = 3'd3;
	localparam logic [2:0] REG_COEF_BOT = 3'd4;
	localparam logic [2:0] REG_RECIP = 3'd5;
	localparam logic [2:0] REG_BORDER = 3'd6;

	typedef logic [31:0] pixel_t;

	typedef struct packed {
		logic             rbase;
		logic             cbase;
		logic             top_out;
		logic             bot_out;
		logic             left_out;
		logic             right_out;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} emit_t;

endpackage

[sv/cv3_ram.sv]
module cv3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/convolution_3x3_rgba_unit.sv]
// 3x3 convolution over an RGBA8 pixel stream in raster order. Two line memories
// hold the previous two lines; each output is the nine-tap Q8.8 weighted sum per
// channel, scaled by the Q8.16 reciprocal, rounded and clamped to 0..255, sent
// with its column and row. Line r-1 comes out while line r arrives; the last line
// (from image_height) comes out as it arrives. An input pixel is read from the
// line memories, then written back as the window shifts; each result it causes
// takes tap steps on one shared tap multiplier per channel, then scale steps on
// the reciprocal multiplier, then a hand-over. The output register lets the next
// pixel enter while the last result waits.
module convolution_3x3_rgba_unit #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cv3_pkg::CFG_AW-1:0]  paddr,
	input  logic [cv3_pkg::CFG_DW-1:0]  pwdata,
	output logic [cv3_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// pixel_red, pixel_green, pixel_blue, pixel_alpha
	input  logic [31:0]                 s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// out_red, out_green, out_blue, out_alpha, out_column, out_row, zero pad
	output logic [55:0]                 m_axis_tdata,
	output logic                        m_axis_tlast
);

	import cv3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_TAP = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_PUSH = 3'd4;

	logic [11:0]              width_q;
	logic [12:0]              height_q;
	logic [COEF_W-1:0]        coef_q [3];
	logic signed [REC_W-1:0]  recip_q;
	logic                     mode_q;

	logic [2:0]               state_q;
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;
	pixel_t                   px_q;
	logic [AW-1:0]            addr_q;
	emit_t                    emit_q [4];
	logic [3:0]               en_q;
	logic [1:0]               e_q;
	logic [1:0]               i_q;
	logic [1:0]               j_q;
	logic [1:0]               ch_q;
	pixel_t                   win_q [9];
	logic signed [ACC_W-1:0]  acc_q [4];
	logic [7:0]               res_q [4];
	logic                     m_valid_q;
	logic [55:0]              m_data_q;
	logic                     m_last_q;

	logic                     cfg_wr;
	logic                     s_accept;
	logic [11:0]              w_c;
	logic [12:0]              h_c;
	logic [COL_W-1:0]         x_cl;
	logic                     eol;
	logic                     last_ln;
	emit_t                    emit_c [4];
	logic [3:0]               en_c;
	pixel_t                   mid_rd;
	pixel_t                   up_rd;
	logic                     ram_we;

	emit_t                    cur;
	logic                     rsub;
	logic                     csub;
	logic [1:0]               ri;
	logic [1:0]               cj;
	logic [2:0]               wr;
	logic [2:0]               wc;
	pixel_t                   tap_px;
	logic [COEF_W-1:0]        coef_row;
	logic signed [15:0]       tap_k;

	logic signed [51:0]       prod;
	logic signed [52:0]       rnd;
	logic [7:0]               sat;

	logic                     out_free;
	logic                     out_load;
	logic [2:0]               nxt;
	logic [2:0]               first;

	function automatic logic [2:0] pick(input logic [3:0] mask, input logic [2:0] start);
		logic [2:0] r;
		r = 3'b000;
		for (int k = 3; k >= 0; k--) begin
			if (mask[k] && (3'(k) >= start)) begin
				r = {1'b1, 2'(k)};
			end
		end
		return r;
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640;
			height_q <= 13'd480;
			coef_q[0] <= '0;
			coef_q[1] <= COEF_W'(256);
			coef_q[2] <= '0;
			recip_q <= REC_W'(65536);
			mode_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_WIDTH: width_q <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				REG_COEF_TOP: coef_q[0] <= pwdata[COEF_W-1:0];
				REG_COEF_MID: coef_q[1] <= pwdata[COEF_W-1:0];
				REG_COEF_BOT: coef_q[2] <= pwdata[COEF_W-1:0];
				REG_RECIP: recip_q <= pwdata[REC_W-1:0];
				REG_BORDER: mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_WIDTH: prdata = 64'(width_q);
			REG_HEIGHT: prdata = 64'(height_q);
			REG_COEF_TOP: prdata = 64'(coef_q[0]);
			REG_COEF_MID: prdata = 64'(coef_q[1]);
			REG_COEF_BOT: prdata = 64'(coef_q[2]);
			REG_RECIP: prdata = 64'(unsigned'(recip_q));
			REG_BORDER: prdata = 64'(mode_q);
			default: prdata = '0;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (width_q == 12'd0) begin
			w_c = 12'd1;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_c = 12'(MAX_WIDTH);
		end else begin
			w_c = width_q;
		end
		if (height_q == 13'd0) begin
			h_c = 13'd1;
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_c = 13'(MAX_HEIGHT);
		end else begin
			h_c = height_q;
		end
		if (32'(col_q) >= 32'(MAX_WIDTH)) begin
			x_cl = COL_W'(MAX_WIDTH - 1);
		end else begin
			x_cl = col_q;
		end
		eol = {1'b0, x_cl} >= (w_c - 12'd1);
		last_ln = {1'b0, row_q} >= (h_c - 13'd1);

		en_c[0] = (row_q != '0) && (x_cl != '0);
		en_c[1] = (row_q != '0) && eol;
		en_c[2] = last_ln && (x_cl != '0);
		en_c[3] = last_ln && eol;

		emit_c[0] = '{rbase: 1'b0, cbase: 1'b0, top_out: row_q == ROW_W'(1), bot_out: 1'b0,
			left_out: x_cl == COL_W'(1), right_out: 1'b0, col: x_cl - COL_W'(1),
			row: row_q - ROW_W'(1)};
		emit_c[1] = '{rbase: 1'b0, cbase: 1'b1, top_out: row_q == ROW_W'(1), bot_out: 1'b0,
			left_out: w_c == 12'd1, right_out: 1'b1, col: COL_W'(w_c - 12'd1),
			row: row_q - ROW_W'(1)};
		emit_c[2] = '{rbase: 1'b1, cbase: 1'b0, top_out: row_q == '0, bot_out: 1'b1,
			left_out: x_cl == COL_W'(1), right_out: 1'b0, col: x_cl - COL_W'(1),
			row: row_q};
		emit_c[3] = '{rbase: 1'b1, cbase: 1'b1, top_out: row_q == '0, bot_out: 1'b1,
			left_out: w_c == 12'd1, right_out: 1'b1, col: COL_W'(w_c - 12'd1),
			row: row_q};
	end

	assign ram_we = (state_q == ST_READ);

	cv3_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line_mid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (px_q),
		.raddr (AW'(x_cl)),
		.rdata (mid_rd)
	);

	cv3_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line_up (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (mid_rd),
		.raddr (AW'(x_cl)),
		.rdata (up_rd)
	);

	always_comb begin
		cur = emit_q[e_q];
		rsub = ((i_q == 2'd0) && cur.top_out) || ((i_q == 2'd2) && cur.bot_out);
		csub = ((j_q == 2'd0) && cur.left_out) || ((j_q == 2'd2) && cur.right_out);
		ri = rsub ? 2'd1 : i_q;
		cj = csub ? 2'd1 : j_q;
		wr = 3'(ri) + 3'(cur.rbase);
		wc = 3'(cj) + 3'(cur.cbase);
		if ((mode_q && (rsub || csub)) || (wr >= 3'd3) || (wc >= 3'd3)) begin
			tap_px = '0;
		end else begin
			tap_px = win_q[4'(wr) * 4'd3 + 4'(wc)];
		end
		case (i_q)
			2'd0: coef_row = coef_q[0];
			2'd1: coef_row = coef_q[1];
			default: coef_row = coef_q[2];
		endcase
		case (j_q)
			2'd0: tap_k = signed'(coef_row[15:0]);
			2'd1: tap_k = signed'(coef_row[31:16]);
			default: tap_k = signed'(coef_row[47:32]);
		endcase

		prod = 52'(acc_q[ch_q]) * 52'(recip_q);
		rnd = 53'(prod) + 53'sd8388608;
		if (rnd[52]) begin
			sat = 8'd0;
		end else if (|rnd[51:32]) begin
			sat = 8'd255;
		end else begin
			sat = rnd[31:24];
		end

		out_free = !m_valid_q || m_axis_tready;
		out_load = (state_q == ST_PUSH) && out_free;
		nxt = pick(en_q, 3'(e_q) + 3'd1);
		first = pick(en_q, 3'd0);
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			px_q <= s_axis_tdata;
			addr_q <= AW'(x_cl);
			for (int k = 0; k < 4; k++) begin
				emit_q[k] <= emit_c[k];
			end
		end
		if (state_q == ST_TAP) begin
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= ((i_q == 2'd0 && j_q == 2'd0) ? '0 : acc_q[c])
					+ ACC_W'($signed({1'b0, tap_px[8*c +: 8]})) * ACC_W'(tap_k);
			end
		end
		if (state_q == ST_SCALE) begin
			res_q[ch_q] <= sat;
		end
		if (out_load) begin
			m_data_q <= {1'b0, cur.row, cur.col, res_q[3], res_q[2], res_q[1], res_q[0]};
			m_last_q <= !nxt[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			en_q <= '0;
			e_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ch_q <= '0;
			m_valid_q <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						en_q <= en_c;
						if (eol) begin
							col_q <= '0;
							row_q <= last_ln ? '0 : row_q + ROW_W'(1);
						end else begin
							col_q <= x_cl + COL_W'(1);
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					for (int k = 0; k < 3; k++) begin
						win_q[k*3] <= win_q[k*3+1];
						win_q[k*3+1] <= win_q[k*3+2];
					end
					win_q[2] <= up_rd;
					win_q[5] <= mid_rd;
					win_q[8] <= px_q;
					i_q <= '0;
					j_q <= '0;
					e_q <= first[1:0];
					state_q <= first[2] ? ST_TAP : ST_IDLE;
				end
				ST_TAP: begin
					if (j_q == 2'd2) begin
						j_q <= '0;
						if (i_q == 2'd2) begin
							i_q <= '0;
							ch_q <= '0;
							state_q <= ST_SCALE;
						end else begin
							i_q <= i_q + 2'd1;
						end
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				ST_SCALE: begin
					ch_q <= ch_q + 2'd1;
					if (ch_q == 2'd3) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						e_q <= nxt[1:0];
						state_q <= nxt[2] ? ST_TAP : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tlast = m_last_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> state_q == ST_READ)
		else $error("accepted pixel did not start a line read");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("computed result was not presented");

	a_push_only_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP || state_q == ST_SCALE || state_q == ST_PUSH) |-> en_q[e_q])
		else $error("working on a result that the pixel does not cause");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAP |-> (i_q != 2'd3) && (j_q != 2'd3))
		else $error("tap counter out of window");

endmodule

[sim/convolution_3x3_rgba_unit_tb.sv]
`timescale 1ns / 100ps

module convolution_3x3_rgba_unit_tb;
	import cv3_pkg::*;

	localparam int MAXW = 2048;

	typedef struct {
		logic [7:0]  ch [4];
		logic [10:0] col;
		logic [11:0] row;
		logic        last;
	} conv_out_t;

	class conv_scoreboard;
		logic [11:0] width_r;
		logic [12:0] height_r;
		logic [47:0] coef [3];
		logic [23:0] recip;
		logic        zero_border;
		logic [31:0] line_mem [2*MAXW];
		logic [31:0] win [9];
		int unsigned col_cnt;
		int unsigned row_cnt;
		conv_out_t   pending [$];
		int          errors;

		function new();
			width_r = 12'd640;
			height_r = 13'd480;
			coef[0] = 48'd0;
			coef[1] = 48'd256;
			coef[2] = 48'd0;
			recip = 24'd65536;
			zero_border = 1'b0;
			foreach (line_mem[i]) line_mem[i] = '0;
			foreach (win[i]) win[i] = '0;
			col_cnt = 0;
			row_cnt = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] v);
			case (idx)
				REG_WIDTH: width_r = v[11:0];
				REG_HEIGHT: height_r = v[12:0];
				REG_COEF_TOP: coef[0] = v[47:0];
				REG_COEF_MID: coef[1] = v[47:0];
				REG_COEF_BOT: coef[2] = v[47:0];
				REG_RECIP: recip = v[23:0];
				REG_BORDER: zero_border = v[0];
				default: ;
			endcase
		endfunction

		function void filter_at(int rb, int cb, bit t_o, bit b_o, bit l_o, bit r_o,
				int unsigned c, int unsigned r);
			logic [31:0] g [3][3];
			conv_out_t   o;
			longint      acc;
			longint      prod;
			logic signed [15:0] k;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					g[i][j] = (rb + i < 3 && cb + j < 3) ? win[(rb + i) * 3 + cb + j] : '0;
			for (int j = 0; j < 3; j++) begin
				if (t_o) g[0][j] = zero_border ? '0 : g[1][j];
				if (b_o) g[2][j] = zero_border ? '0 : g[1][j];
			end
			for (int i = 0; i < 3; i++) begin
				if (l_o) g[i][0] = zero_border ? '0 : g[i][1];
				if (r_o) g[i][2] = zero_border ? '0 : g[i][1];
			end
			for (int ch = 0; ch < 4; ch++) begin
				acc = 0;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						k = coef[i][16*j +: 16];
						acc += longint'(g[i][j][8*ch +: 8]) * longint'(k);
					end
				prod = acc * longint'($signed(recip)) + (64'sd1 <<< 23);
				if (prod < 0) o.ch[ch] = 8'd0;
				else if ((prod >>> 24) > 255) o.ch[ch] = 8'd255;
				else o.ch[ch] = prod[31:24];
			end
			o.col = c[10:0];
			o.row = r[11:0];
			o.last = 1'b0;
			pending.push_back(o);
		endfunction

		function void note_pixel(logic [31:0] px);
			int unsigned w, h, x, r, n0;
			bit eol, lastl;
			logic [31:0] up, mid;
			w = width_r == 0 ? 1 : (width_r > MAXW ? MAXW : width_r);
			h = height_r == 0 ? 1 : (height_r > 4096 ? 4096 : height_r);
			x = col_cnt >= MAXW ? MAXW - 1 : col_cnt;
			r = row_cnt;
			eol = x >= w - 1;
			lastl = r >= h - 1;
			up = line_mem[MAXW + x];
			mid = line_mem[x];
			line_mem[MAXW + x] = mid;
			line_mem[x] = px;
			for (int i = 0; i < 3; i++) begin
				win[i*3] = win[i*3+1];
				win[i*3+1] = win[i*3+2];
			end
			win[2] = up;
			win[5] = mid;
			win[8] = px;
			n0 = pending.size();
			if (r >= 1) begin
				if (x >= 1) filter_at(0, 0, r == 1, 0, x == 1, 0, x - 1, r - 1);
				if (eol) filter_at(0, 1, r == 1, 0, w == 1, 1, w - 1, r - 1);
			end
			if (lastl) begin
				if (x >= 1) filter_at(1, 0, r == 0, 1, x == 1, 0, x - 1, r);
				if (eol) filter_at(1, 1, r == 0, 1, w == 1, 1, w - 1, r);
			end
			if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
			if (eol) begin
				col_cnt = 0;
				row_cnt = lastl ? 0 : ((r + 1) & 12'hfff);
			end else begin
				col_cnt = (x + 1) & 11'h7ff;
			end
		endfunction

		function void check_result(logic [55:0] d, logic tl);
			conv_out_t e;
			logic [55:0] ed;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h last %b", $time, d, tl);
				errors++;
				return;
			end
			e = pending.pop_front();
			ed = {33'd0, 23'd0};
			ed[31:0] = {e.ch[3], e.ch[2], e.ch[1], e.ch[0]};
			ed[42:32] = e.col;
			ed[54:43] = e.row;
			if (d !== ed || tl !== e.last) begin
				$display("%0t: expected %h last %b, actual %h last %b", $time, ed, e.last, d, tl);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata, prdata;
	logic pready;
	logic s_axis_tvalid, s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic m_axis_tlast;

	conv_scoreboard sb;
	bit quiet;
	bit hold_rx;

	convolution_3x3_rgba_unit uut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= CFG_AW'(idx) << 3;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [31:0] px);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(px);
	endtask

	task automatic drain();
		int n;
		s_axis_tvalid <= 0;
		n = 0;
		while (sb.pending.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic send_frame(int w, int h, bit rnd);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				send_pixel(rnd ? $urandom : ((c + r) % 2 ? 32'hffffffff : 32'h0));
	endtask

	task automatic random_setup(int w, int h);
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
		write_reg(REG_COEF_TOP, {$urandom, $urandom});
		write_reg(REG_COEF_MID, {$urandom, $urandom});
		write_reg(REG_COEF_BOT, {$urandom, $urandom});
		write_reg(REG_RECIP, $urandom_range(0, 3) == 0 ? 64'(24'h800000 | $urandom_range(0, 255))
			: 64'($urandom_range(0, 400)));
		write_reg(REG_BORDER, 64'($urandom_range(0, 1)));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
	end

	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int sent;
		bit held;
		sb = new();
		quiet = 0;
		hold_rx = 0;
		held = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(REG_WIDTH, 64'd3);
		write_reg(REG_HEIGHT, 64'd3);
		send_frame(3, 3, 0);
		drain();
		write_reg(REG_BORDER, 64'd1);
		write_reg(REG_COEF_TOP, 64'h7fff_8000_0100);
		write_reg(REG_COEF_MID, 64'h0100_7fff_ffff);
		write_reg(REG_COEF_BOT, 64'h8000_0100_7fff);
		write_reg(REG_RECIP, 64'h7fffff);
		send_frame(3, 2, 0);
		drain();
		write_reg(REG_RECIP, 64'h800000);
		write_reg(REG_WIDTH, 64'd1);
		write_reg(REG_HEIGHT, 64'd1);
		send_pixel(32'hffffffff);
		send_pixel(32'h00000000);
		drain();
		write_reg(REG_RECIP, 64'd0);
		write_reg(REG_WIDTH, 64'd2);
		write_reg(REG_HEIGHT, 64'd2);
		send_frame(2, 2, 1);
		drain();
		sent = 0;
		while (sent < 420) begin
			int w, h;
			w = $urandom_range(0, 7) == 0 ? $urandom_range(1, 20) : $urandom_range(1, 6);
			h = $urandom_range(1, 6);
			if (sent > 380) quiet = 1;
			random_setup(w, h);
			if (sent > 100 && !held) begin
				hold_rx = 1;
				held = 1;
			end
			send_frame(w, h, 1);
			sent += w * h;
			drain();
		end
		random_setup(2, 2);
		write_reg(REG_WIDTH, 64'hfff);
		write_reg(REG_HEIGHT, 64'd0);
		send_frame(8, 1, 1);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
